// File: src/ssp_pkg.sv
// Shared constants and types for the sequential servo pulse generator.
package ssp_pkg;

	// Frame timing, in 0.5 us ticks.
	localparam logic [15:0] FRAME_TICKS   = 16'd40000;
	localparam logic [15:0] STARTUP_TICKS = 16'd100;
	localparam int unsigned NUM_SERVOS    = 3;

	// Pulse limits, in microseconds and degrees.
	localparam logic [15:0] PULSE_MIN_US = 16'd500;
	localparam logic [15:0] PULSE_MAX_US = 16'd2400;
	localparam logic [15:0] ANGLE_MAX    = 16'd180;

	// Width of one pulse in ticks (at most 4800).
	localparam int unsigned TICKS_W = 13;

	// Configuration register indexes.
	localparam logic [2:0] REG_SERVO1_SETTING = 3'd0;
	localparam logic [2:0] REG_SERVO2_SETTING = 3'd1;
	localparam logic [2:0] REG_SERVO3_SETTING = 3'd2;
	localparam logic [2:0] REG_ANGLE_MASK     = 3'd3;
	localparam logic [2:0] REG_ENABLE_MASK    = 3'd4;

	// Phase codes: pulse slots for servos one to three, then the frame gap.
	localparam logic [1:0] PHASE_SERVO1 = 2'd0;
	localparam logic [1:0] PHASE_SERVO2 = 2'd1;
	localparam logic [1:0] PHASE_SERVO3 = 2'd2;
	localparam logic [1:0] PHASE_GAP    = 2'd3;

	// One result beat.
	typedef struct packed {
		logic [NUM_SERVOS-1:0] levels;
		logic [1:0]            phase;
	} result_t;

endpackage

// File: src/ssp_pulse_width.sv
// Converts one servo setting into a pulse width in ticks.
module ssp_pulse_width import ssp_pkg::*; (
	input  logic [15:0]        setting,
	input  logic               is_angle,
	output logic [TICKS_W-1:0] ticks
);

	logic [7:0]  angle;
	logic [15:0] angle_us;
	logic [15:0] raw_us;
	logic [15:0] clamped_us;

	// Angle path: 500 + 10a + a/2, with the angle saturated at its maximum.
	always_comb begin
		angle = (setting > ANGLE_MAX) ? ANGLE_MAX[7:0] : setting[7:0];
		angle_us = PULSE_MIN_US + {5'd0, angle, 3'd0} + {7'd0, angle, 1'b0}
			+ {9'd0, angle[7:1]};
	end

	// Saturate to the legal pulse range and double into ticks.
	always_comb begin
		raw_us = is_angle ? angle_us : setting;
		if (raw_us < PULSE_MIN_US) begin
			clamped_us = PULSE_MIN_US;
		end else if (raw_us > PULSE_MAX_US) begin
			clamped_us = PULSE_MAX_US;
		end else begin
			clamped_us = raw_us;
		end
		ticks = {clamped_us[TICKS_W-2:0], 1'b0};
	end

endmodule

// File: src/ssp_out_buf.sv
// Two-entry result buffer: an output register plus a skid register.
module ssp_out_buf import ssp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign space     = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign pop       = main_valid_q & out_ready;

	// Control: the skid entry refills the output register first, so beats stay in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// File: src/sequential_servo_pulse_generator_core.sv
// Top level of the sequential three-channel servo pulse generator.
// Output: a tick beat's result is registered in the output buffer and offered from its output register.
// Throughput: one tick beat per cycle while results are taken; a two-entry output buffer keeps input
// flowing while one result waits.
// Reset: asynchronous, active low; starts in the frame gap with a 100-tick delay,
// all sequencer pin levels low, settings at 1500 us, both masks clear.
module sequential_servo_pulse_generator_core import ssp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick_valid,
	output logic        tick_ready,
	input  logic        tick,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        servo1_level,
	output logic        servo2_level,
	output logic        servo3_level,
	output logic [1:0]  frame_phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]           servo1_setting_q;
	logic [15:0]           servo2_setting_q;
	logic [15:0]           servo3_setting_q;
	logic [NUM_SERVOS-1:0] angle_mask_q;
	logic [NUM_SERVOS-1:0] enable_mask_q;
	logic [1:0]            phase_q;
	logic [15:0]           countdown_q;
	logic [15:0]           frame_used_q;
	logic [NUM_SERVOS-1:0] levels_q;

	logic                  accept;
	logic                  cfg_write;
	logic [1:0]            slot;
	logic [15:0]           slot_setting;
	logic                  slot_angle;
	logic [TICKS_W-1:0]    slot_ticks;
	logic [15:0]           slot_ticks_ext;
	logic [1:0]            phase_d;
	logic [15:0]           countdown_d;
	logic [15:0]           frame_used_d;
	logic [NUM_SERVOS-1:0] levels_d;
	result_t               result_d;
	result_t               result_out;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;
	assign accept    = tick_valid & tick_ready;

	// Next pulse slot and its setting.
	always_comb begin
		slot = (phase_q == PHASE_GAP) ? PHASE_SERVO1 : (phase_q + 2'd1);
		case (slot)
			PHASE_SERVO1: slot_setting = servo1_setting_q;
			PHASE_SERVO2: slot_setting = servo2_setting_q;
			PHASE_SERVO3: slot_setting = servo3_setting_q;
			default:      slot_setting = servo1_setting_q;
		endcase
		slot_angle = angle_mask_q[slot];
	end

	ssp_pulse_width u_width (
		.setting  (slot_setting),
		.is_angle (slot_angle),
		.ticks    (slot_ticks)
	);

	assign slot_ticks_ext = {{(16 - TICKS_W){1'b0}}, slot_ticks};

	// Phase sequencer: count down, and at the end of a phase start the next one.
	always_comb begin
		phase_d      = phase_q;
		countdown_d  = countdown_q;
		frame_used_d = frame_used_q;
		levels_d     = levels_q;
		if (tick) begin
			if (countdown_q <= 16'd1) begin
				if (phase_q != PHASE_GAP) begin
					levels_d[phase_q] = 1'b0;
				end
				if (phase_q == PHASE_SERVO3) begin
					phase_d     = PHASE_GAP;
					countdown_d = FRAME_TICKS - frame_used_q;
				end else begin
					phase_d     = slot;
					countdown_d = slot_ticks_ext;
					if (slot == PHASE_SERVO1) begin
						frame_used_d = slot_ticks_ext;
					end else begin
						frame_used_d = frame_used_q + slot_ticks_ext;
					end
					if (enable_mask_q[slot]) begin
						levels_d[slot] = 1'b1;
					end
				end
			end else begin
				countdown_d = countdown_q - 16'd1;
			end
		end
		result_d.levels = levels_d;
		result_d.phase  = phase_d;
	end

	// Sequencer state and output pin levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PHASE_GAP;
			countdown_q  <= STARTUP_TICKS;
			frame_used_q <= 16'd0;
			levels_q     <= '0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				countdown_q  <= countdown_d;
				frame_used_q <= frame_used_d;
			end
			if (cfg_write && cfg_index == REG_ENABLE_MASK) begin
				// Clearing an enable bit drops that pin at once.
				levels_q <= (accept ? levels_d : levels_q) & cfg_data[NUM_SERVOS-1:0];
			end else if (accept) begin
				levels_q <= levels_d;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo1_setting_q <= 16'd1500;
			servo2_setting_q <= 16'd1500;
			servo3_setting_q <= 16'd1500;
			angle_mask_q     <= '0;
			enable_mask_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SERVO1_SETTING: servo1_setting_q <= cfg_data;
				REG_SERVO2_SETTING: servo2_setting_q <= cfg_data;
				REG_SERVO3_SETTING: servo3_setting_q <= cfg_data;
				REG_ANGLE_MASK:     angle_mask_q     <= cfg_data[NUM_SERVOS-1:0];
				REG_ENABLE_MASK:    enable_mask_q    <= cfg_data[NUM_SERVOS-1:0];
				default:            ;
			endcase
		end
	end

	// Result beats go through the output buffer.
	ssp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result_d),
		.space     (tick_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result_out)
	);

	assign servo1_level = result_out.levels[0];
	assign servo2_level = result_out.levels[1];
	assign servo3_level = result_out.levels[2];
	assign frame_phase  = result_out.phase;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the sequential servo pulse generator core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssp_pkg::*;

	// Run limit in clock cycles, well above the slowest passing run.
	localparam int unsigned LIMIT = 200000;
	// Number of codes the register index port can carry.
	localparam int unsigned REG_SLOTS = 8;

	// Tracks the pulse train the block should produce and checks each result beat.
	class servo_scoreboard;
		logic [15:0]           setting [NUM_SERVOS];
		logic [NUM_SERVOS-1:0] angle_bits;
		logic [NUM_SERVOS-1:0] enable_bits;
		logic [1:0]            phase;
		logic [15:0]           countdown;
		logic [15:0]           frame_used;
		logic [NUM_SERVOS-1:0] levels;
		result_t               expected_q [$];
		int unsigned           errors;
		int unsigned           checked;
		int unsigned           ticks;
		int unsigned           frames;

		function new();
			// Power-up settings are 1500 us for every servo.
			foreach (setting[i]) setting[i] = 16'd1500;
			angle_bits  = '0;
			enable_bits = '0;
			phase       = PHASE_GAP;
			countdown   = STARTUP_TICKS;
			frame_used  = '0;
			levels      = '0;
			errors      = 0;
			checked     = 0;
			ticks       = 0;
			frames      = 0;
		endfunction

		// Pulse width in ticks for one servo, from its setting and angle bit.
		function logic [15:0] width_ticks(logic [1:0] slot);
			int unsigned v;
			int unsigned us;
			v = setting[slot];
			if (angle_bits[slot]) begin
				if (v > ANGLE_MAX) v = ANGLE_MAX;
				us = PULSE_MIN_US + v * 10 + v / 2;
			end else begin
				us = v;
			end
			if (us < PULSE_MIN_US) us = PULSE_MIN_US;
			if (us > PULSE_MAX_US) us = PULSE_MAX_US;
			return 16'(us * 2);
		endfunction

		// A pulse slot samples its setting and raises the pin if enabled.
		function void open_slot(logic [1:0] slot);
			logic [15:0] w;
			w = width_ticks(slot);
			if (enable_bits[slot]) levels[slot] = 1'b1;
			countdown  = w;
			frame_used = (slot == PHASE_SERVO1) ? w : frame_used + w;
			phase      = slot;
			if (slot == PHASE_SERVO1) frames++;
		endfunction

		// The countdown ran out: drop the active pin and move to the next phase.
		function void close_phase();
			if (phase == PHASE_GAP) begin
				open_slot(PHASE_SERVO1);
			end else begin
				levels[phase] = 1'b0;
				if (phase == PHASE_SERVO3) begin
					phase     = PHASE_GAP;
					countdown = FRAME_TICKS - frame_used;
				end else begin
					open_slot(phase + 2'd1);
				end
			end
		endfunction

		// Register write; clearing an enable bit drops that pin at once.
		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_SERVO1_SETTING, REG_SERVO2_SETTING, REG_SERVO3_SETTING: begin
					setting[idx] = data;
				end
				REG_ANGLE_MASK: begin
					angle_bits = data[NUM_SERVOS-1:0];
				end
				REG_ENABLE_MASK: begin
					enable_bits = data[NUM_SERVOS-1:0];
					levels      = levels & enable_bits;
				end
				default: begin
				end
			endcase
		endfunction

		// One accepted input beat: advance the timer and queue the levels it leaves.
		function void note_tick(logic t);
			result_t r;
			if (t) begin
				ticks++;
				if (countdown <= 16'd1) begin
					countdown = '0;
					close_phase();
				end else begin
					countdown = countdown - 16'd1;
				end
			end
			r.levels = levels;
			r.phase  = phase;
			expected_q.push_back(r);
		endfunction

		// Compare one result beat with the oldest expectation, field by field.
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, got levels %b phase %0d",
					$time, got.levels, got.phase);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				if (got.levels[i] !== want.levels[i]) begin
					errors++;
					$display("%0t: servo%0d level mismatch, expected %b, got %b",
						$time, i + 1, want.levels[i], got.levels[i]);
				end
			end
			if (got.phase !== want.phase) begin
				errors++;
				$display("%0t: frame_phase mismatch, expected %0d, got %0d",
					$time, want.phase, got.phase);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        tick_valid   = 1'b0;
	logic        tick_ready;
	logic        tick         = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        servo1_level;
	logic        servo2_level;
	logic        servo3_level;
	logic [1:0]  frame_phase;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index    = '0;
	logic [15:0] cfg_data     = '0;

	servo_scoreboard sb;
	int unsigned     cycles       = 0;
	int unsigned     cfg_writes   = 0;
	int              tx_idle_pct  = 0;
	int              rx_stall_pct = 0;

	sequential_servo_pulse_generator_core i_dut (.*);

	always #10 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls at random according to the current idling mode.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Monitor: note each accepted input beat, then check each accepted result beat.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && tick_valid && tick_ready) sb.note_tick(tick);
		if (arst_n && result_valid && result_ready) begin
			got.levels = {servo3_level, servo2_level, servo1_level};
			got.phase  = frame_phase;
			sb.check_result(got);
		end
	end

	// Offer one tick beat, idling first at random, and wait until it is taken.
	task automatic send_tick(input logic t);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= t;
		do @(posedge clk); while (!tick_ready);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Register write; the caller lowers cfg_valid after the last of a group.
	task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic tick_count(input int n, input int one_pct);
		repeat (n) send_tick($urandom_range(0, 99) < one_pct);
	endtask

	task automatic tick_until(input logic [1:0] target, input int one_pct);
		while (sb.phase != target) send_tick($urandom_range(0, 99) < one_pct);
	endtask

	// Setting values weighted toward the saturation and angle boundaries.
	function automatic logic [15:0] pick_setting();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return PULSE_MIN_US - 16'd1;
			2:       return PULSE_MIN_US;
			3:       return PULSE_MAX_US;
			4:       return PULSE_MAX_US + 16'd1;
			5:       return ANGLE_MAX + 16'd1;
			6:       return 16'($urandom_range(0, ANGLE_MAX + 10));
			7:       return 16'($urandom_range(PULSE_MIN_US, PULSE_MAX_US));
			8:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Rewrite a random subset of the registers, sometimes an unmapped index too.
	task automatic shuffle_settings();
		if ($urandom_range(0, 2) != 0) write_cfg(REG_SERVO1_SETTING, pick_setting());
		if ($urandom_range(0, 2) != 0) write_cfg(REG_SERVO2_SETTING, pick_setting());
		if ($urandom_range(0, 2) != 0) write_cfg(REG_SERVO3_SETTING, pick_setting());
		if ($urandom_range(0, 2) != 0) write_cfg(REG_ANGLE_MASK, 16'($urandom));
		if ($urandom_range(0, 2) != 0) write_cfg(REG_ENABLE_MASK, 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_cfg(3'($urandom_range(REG_ENABLE_MASK + 1, REG_SLOTS - 1)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// One idling mode: ticks, a register update, then more ticks.
	task automatic idle_phase(input int tx_pct, input int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		tick_count($urandom_range(60, 120), 90);
		wait_drained();
		shuffle_settings();
		tick_count(40, 90);
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Holds and a few ticks in the start-up gap, all pins disabled.
		repeat (4) send_tick(1'b0);
		repeat (6) send_tick(1'b1);
		wait_drained();

		// Extremes: clamp from zero, clamp from all ones, largest angle; unmapped indexes.
		write_cfg(REG_SERVO1_SETTING, 16'h0000);
		write_cfg(REG_SERVO2_SETTING, 16'hFFFF);
		write_cfg(REG_SERVO3_SETTING, ANGLE_MAX);
		write_cfg(REG_ANGLE_MASK, 16'hFFFC);
		write_cfg(REG_ENABLE_MASK, 16'h0007);
		for (int i = REG_ENABLE_MASK + 1; i < REG_SLOTS; i++) write_cfg(3'(i), 16'hFFFF);
		cfg_valid <= 1'b0;

		// Leave the start-up delay with no idling; servo one's pulse begins.
		tick_until(PHASE_SERVO1, 100);

		// Disable servo one while its pin is high, then enable it again mid-pulse.
		tick_count(30, 100);
		wait_drained();
		write_cfg(REG_ENABLE_MASK, 16'h0006);
		cfg_valid <= 1'b0;
		tick_count(20, 100);
		wait_drained();
		write_cfg(REG_ENABLE_MASK, 16'h0007);

		// Settings changed mid-phase, including an angle beyond the limit.
		write_cfg(REG_SERVO1_SETTING, PULSE_MAX_US);
		write_cfg(REG_SERVO2_SETTING, ANGLE_MAX + 16'd20);
		write_cfg(REG_SERVO3_SETTING, 16'd1);
		write_cfg(REG_ANGLE_MASK, 16'h0002);
		cfg_valid <= 1'b0;
		tick_count(40, 90);

		// Sender idling, receiver stalls and both.
		idle_phase(58, 0);
		idle_phase(0, 58);
		idle_phase(25, 25);

		// Short random bursts with fresh settings and a random idling mode each.
		repeat (4) begin
			wait_drained();
			shuffle_settings();
			case ($urandom_range(0, 3))
				0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1:       begin tx_idle_pct = 58; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 58; end
				default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
			endcase
			tick_count(20, $urandom_range(30, 100));
		end

		// Drain the outstanding results, then report.
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Summary: %0d timer ticks, %0d result beats checked, %0d frames started.",
			sb.ticks, sb.checked, sb.frames);
		$display("Summary: %0d register writes, clamped, angle and disabled pins, four idling modes.",
			cfg_writes);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
